>>> design/cpd_pkg.sv
// Shared types and constants for the candlestick pattern detector.
// No dependencies; used by every module of the block.
package cpd_pkg;

  localparam int PRICE_BITS_DEF = 32;
  localparam int PORT_BITS      = 32;
  // extra headroom over the price width for signed differences times constants
  localparam int GUARD_BITS     = 8;

  // scale factors of the ratio tests, all compared by cross-multiplication
  localparam int K_DOJI_BODY    = 10;
  localparam int K_WICK_BODY    = 2;
  localparam int K_MARU_WICK    = 50;
  localparam int K_MARU_BODY    = 20;
  localparam int K_MARU_RANGE   = 19;
  localparam int K_BIG_BODY     = 5;
  localparam int K_BIG_RANGE    = 3;

  // one-bar facts
  typedef struct packed {
    logic range_zero;
    logic green;
    logic red;
    logic doji;
    logic big_body;
    logic hammer;
    logic upper_spike;
    logic wicks_small;
  } bar_flags_t;

  // result item
  typedef struct packed {
    logic doji;
    logic hammer;
    logic upper_spike;
    logic solid_bull;
    logic solid_bear;
    logic engulf_bull;
    logic engulf_bear;
    logic harami_bull;
    logic harami_bear;
    logic three_bar_bull;
    logic three_bar_bear;
  } pattern_t;

endpackage

>>> design/cpd_bar_eval.sv
// One-bar shape tests: body, wicks and range compared by scaled integers.
// Depends on cpd_pkg.
module cpd_bar_eval #(
  parameter int PRICE_BITS = cpd_pkg::PRICE_BITS_DEF
) (
  input  logic [PRICE_BITS-1:0] open_p,
  input  logic [PRICE_BITS-1:0] high_p,
  input  logic [PRICE_BITS-1:0] low_p,
  input  logic [PRICE_BITS-1:0] close_p,
  output cpd_pkg::bar_flags_t   flags
);
  import cpd_pkg::*;

  localparam int D = PRICE_BITS + GUARD_BITS;

  localparam logic signed [D-1:0] C_DOJI  = D'(K_DOJI_BODY);
  localparam logic signed [D-1:0] C_WICK  = D'(K_WICK_BODY);
  localparam logic signed [D-1:0] C_MW    = D'(K_MARU_WICK);
  localparam logic signed [D-1:0] C_MB    = D'(K_MARU_BODY);
  localparam logic signed [D-1:0] C_MR    = D'(K_MARU_RANGE);
  localparam logic signed [D-1:0] C_BB    = D'(K_BIG_BODY);
  localparam logic signed [D-1:0] C_BR    = D'(K_BIG_RANGE);
  localparam logic signed [D-1:0] C_ZERO  = D'(0);

  logic signed [D-1:0] o, h, l, c;
  logic signed [D-1:0] top_oc, bot_oc;
  logic signed [D-1:0] body, range_v, upper, lower;

  always_comb begin
    o = $signed({{GUARD_BITS{1'b0}}, open_p});
    h = $signed({{GUARD_BITS{1'b0}}, high_p});
    l = $signed({{GUARD_BITS{1'b0}}, low_p});
    c = $signed({{GUARD_BITS{1'b0}}, close_p});
    top_oc  = (o > c) ? o : c;
    bot_oc  = (o < c) ? o : c;
    body    = top_oc - bot_oc;
    range_v = h - l;
    upper   = h - top_oc;
    lower   = bot_oc - l;

    flags.range_zero    = (high_p == low_p);
    flags.green         = (close_p > open_p);
    flags.red           = (close_p < open_p);
    flags.doji          = (C_DOJI * body) < range_v;
    flags.big_body      = (C_BB * body) > (C_BR * range_v);
    // signed zero so an inverted bar (high below low) fails the range test
    flags.hammer        = (lower > C_WICK * body) && (C_WICK * upper < body)
                          && (range_v > C_ZERO);
    flags.upper_spike   = (upper > C_WICK * body) && (C_WICK * lower < body)
                          && (range_v > C_ZERO);
    flags.wicks_small   = (C_MW * upper < range_v) && (C_MW * lower < range_v)
                          && (C_MB * body > C_MR * range_v);
  end

endmodule

>>> design/cpd_pattern.sv
// Combines one-bar facts of three bars with cross-bar price compares.
// Depends on cpd_pkg.
module cpd_pattern #(
  parameter int PRICE_BITS = cpd_pkg::PRICE_BITS_DEF
) (
  input  logic [PRICE_BITS-1:0] cur_open,
  input  logic [PRICE_BITS-1:0] cur_close,
  input  logic [PRICE_BITS-1:0] prev_open,
  input  logic [PRICE_BITS-1:0] prev_close,
  input  logic [PRICE_BITS-1:0] older_open,
  input  logic                  older_valid,
  input  cpd_pkg::bar_flags_t   cur_f,
  input  cpd_pkg::bar_flags_t   prev_f,
  input  cpd_pkg::bar_flags_t   older_f,
  output cpd_pkg::pattern_t     pat
);
  import cpd_pkg::*;

  logic open_below, open_above, close_above, close_below, mid_ok;

  always_comb begin
    open_below  = cur_open < prev_close;
    open_above  = cur_open > prev_close;
    close_above = cur_close > prev_open;
    close_below = cur_close < prev_open;
    mid_ok      = older_valid && prev_f.doji && older_f.big_body;

    pat = '0;
    if (!cur_f.range_zero) begin
      pat.doji           = cur_f.doji;
      pat.hammer         = cur_f.hammer;
      pat.upper_spike    = cur_f.upper_spike;
      pat.solid_bull     = cur_f.green && cur_f.wicks_small;
      pat.solid_bear     = cur_f.red && cur_f.wicks_small;
      pat.engulf_bull    = prev_f.red && cur_f.green && open_below && close_above;
      pat.engulf_bear    = prev_f.green && cur_f.red && open_above && close_below;
      pat.harami_bull    = prev_f.red && cur_f.green && open_above && close_below;
      pat.harami_bear    = prev_f.green && cur_f.red && open_below && close_above;
      pat.three_bar_bull = mid_ok && older_f.red && cur_f.green
                           && (cur_close > older_open);
      pat.three_bar_bear = mid_ok && older_f.green && cur_f.red
                           && (cur_close < older_open);
    end
  end

endmodule

>>> design/candlestick_pattern_detector_top.sv
// Items go through the input register, then their results through the result register.
// One item per cycle while out_ready is high; input register, shape logic, result register.
// The input stage keeps accepting while a result waits, up to one item.
// Reset clears both stage valids and the two-bars-back history (zero, not valid).
// Top level of the candlestick pattern detector; depends on cpd_pkg,
// cpd_bar_eval and cpd_pattern.
module candlestick_pattern_detector_top #(
  parameter int PRICE_BITS = cpd_pkg::PRICE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cpd_pkg::PORT_BITS-1:0] cur_open,
  input  logic [cpd_pkg::PORT_BITS-1:0] cur_high,
  input  logic [cpd_pkg::PORT_BITS-1:0] cur_low,
  input  logic [cpd_pkg::PORT_BITS-1:0] cur_close,
  input  logic [cpd_pkg::PORT_BITS-1:0] prev_open,
  input  logic [cpd_pkg::PORT_BITS-1:0] prev_high,
  input  logic [cpd_pkg::PORT_BITS-1:0] prev_low,
  input  logic [cpd_pkg::PORT_BITS-1:0] prev_close,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         doji,
  output logic                         hammer,
  output logic                         upper_spike,
  output logic                         solid_bull,
  output logic                         solid_bear,
  output logic                         engulf_bull,
  output logic                         engulf_bear,
  output logic                         harami_bull,
  output logic                         harami_bear,
  output logic                         three_bar_bull,
  output logic                         three_bar_bear
);
  import cpd_pkg::*;

  localparam int W = PRICE_BITS;

  logic [W-1:0] in_p [8];
  logic [PORT_BITS-1:0] in_raw [8];

  // input register
  logic         s1_valid;
  logic [W-1:0] s1_p [8];
  // history: bar from two steps back
  logic [W-1:0] older_open, older_high, older_low, older_close;
  logic         older_valid;
  // result register
  logic         s2_valid;
  pattern_t     result;

  logic       adv2, adv1, take;
  bar_flags_t cur_f, prev_f, older_f;
  pattern_t   pat;

  assign in_raw[0] = cur_open;
  assign in_raw[1] = cur_high;
  assign in_raw[2] = cur_low;
  assign in_raw[3] = cur_close;
  assign in_raw[4] = prev_open;
  assign in_raw[5] = prev_high;
  assign in_raw[6] = prev_low;
  assign in_raw[7] = prev_close;

  // bits above the price width are dropped; narrower ports zero-extend
  for (genvar i = 0; i < 8; i++) begin : g_fit
    if (W > PORT_BITS) begin : g_wide
      assign in_p[i] = {{(W-PORT_BITS){1'b0}}, in_raw[i]};
    end else begin : g_narrow
      assign in_p[i] = in_raw[i][W-1:0];
    end
  end

  assign adv2     = !s2_valid || out_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;
  assign take     = s1_valid && adv2;

  cpd_bar_eval #(.PRICE_BITS(W)) u_cur (
    .open_p(s1_p[0]), .high_p(s1_p[1]), .low_p(s1_p[2]), .close_p(s1_p[3]),
    .flags(cur_f)
  );

  cpd_bar_eval #(.PRICE_BITS(W)) u_prev (
    .open_p(s1_p[4]), .high_p(s1_p[5]), .low_p(s1_p[6]), .close_p(s1_p[7]),
    .flags(prev_f)
  );

  cpd_bar_eval #(.PRICE_BITS(W)) u_older (
    .open_p(older_open), .high_p(older_high), .low_p(older_low),
    .close_p(older_close), .flags(older_f)
  );

  cpd_pattern #(.PRICE_BITS(W)) u_pat (
    .cur_open(s1_p[0]), .cur_close(s1_p[3]),
    .prev_open(s1_p[4]), .prev_close(s1_p[7]),
    .older_open(older_open), .older_valid(older_valid),
    .cur_f(cur_f), .prev_f(prev_f), .older_f(older_f),
    .pat(pat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      older_valid <= 1'b0;
      older_open  <= '0;
      older_high  <= '0;
      older_low   <= '0;
      older_close <= '0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      // history moves only with an item of nonzero range
      if (take && !cur_f.range_zero) begin
        older_open  <= s1_p[4];
        older_high  <= s1_p[5];
        older_low   <= s1_p[6];
        older_close <= s1_p[7];
        older_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_p <= in_p;
    end
    if (take) begin
      result <= pat;
    end
  end

  assign out_valid      = s2_valid;
  assign doji           = result.doji;
  assign hammer         = result.hammer;
  assign upper_spike    = result.upper_spike;
  assign solid_bull     = result.solid_bull;
  assign solid_bear     = result.solid_bear;
  assign engulf_bull    = result.engulf_bull;
  assign engulf_bear    = result.engulf_bear;
  assign harami_bull    = result.harami_bull;
  assign harami_bear    = result.harami_bear;
  assign three_bar_bull = result.three_bar_bull;
  assign three_bar_bear = result.three_bar_bear;

  // input side stalls only behind a full result register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  a_hist_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(older_valid))
    else $error("history valid dropped");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(solid_bull && solid_bear) && !(engulf_bull && engulf_bear)
      && !(harami_bull && harami_bear) && !(three_bar_bull && three_bar_bear)
      && !(hammer && upper_spike))
    else $error("opposing patterns flagged together");

  a_star_hist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (three_bar_bull || three_bar_bear)) |-> older_valid)
    else $error("star pattern without history");

endmodule
